/* src/residue_class_cover_check_defines.svh */
// Assertion macros for the residue class cover check.
`ifndef RESIDUE_CLASS_COVER_CHECK_DEFINES_SVH
`define RESIDUE_CLASS_COVER_CHECK_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RCC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RCC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/rcc_pkg.sv */
// Package: types, constants and helpers of the residue class cover check.
`timescale 1ns / 1ps
package rcc_pkg;
  localparam int NUM_CLASSES_DEF = 21;
  localparam int CLASS_DEPTH_DEF = 1024;
  localparam int EXP_W = 5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ORDER     = 2'd2,
    ST_BASIC     = 2'd3
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  class_exponent;
    logic [31:0] entry_residue;
    logic [31:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic        covered;
    logic [1:0]  status;
  } out_item_t;

  // Queue entry between front and back: classified work.
  typedef struct packed {
    logic        is_query;
    logic        quick;       // result known in the front
    logic        covered;
    logic [1:0]  status;
    logic [31:0] value;       // query value, or residue to store
    logic [4:0]  exponent;    // class for a store
  } work_t;

  function automatic logic is_basic(input logic [4:0] e);
    return (e == 5'd1) || (e == 5'd2) || (e == 5'd4) || (e == 5'd6);
  endfunction
endpackage

/* src/rcc_modunit.sv */
// Base-3 remainder stepper: n mod 3^k for k = 0, 1, 2, ..., one power per two steps.
`timescale 1ns / 1ps
module rcc_modunit import rcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] dividend,
  input  logic        div_step,
  input  logic        acc_step,
  output logic [31:0] remainder
);
  // floor(q / 3) = (q * RECIP3) >> 33 for every 32-bit q
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  logic [31:0] quo_r, quo_nxt;   // n / 3^k
  logic [31:0] q3_r, q3_nxt;     // quo_r / 3
  logic [31:0] rem_r, rem_nxt;   // n mod 3^k
  logic [31:0] pw_r, pw_nxt;     // 3^k
  logic [63:0] prod;
  logic [31:0] three_q3;
  logic [1:0]  digit;

  // Divide step takes the next base-3 quotient; accumulate step adds digit * 3^k
  always_comb begin
    prod     = {32'd0, quo_r} * {32'd0, RECIP3};
    three_q3 = q3_r + {q3_r[30:0], 1'b0};
    digit    = 2'(quo_r - three_q3);
    quo_nxt  = quo_r;
    q3_nxt   = q3_r;
    rem_nxt  = rem_r;
    pw_nxt   = pw_r;
    if (load) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      pw_nxt  = 32'd1;
    end else if (div_step) begin
      q3_nxt = {1'b0, prod[63:33]};
    end else if (acc_step) begin
      quo_nxt = q3_r;
      pw_nxt  = pw_r + {pw_r[30:0], 1'b0};
      case (digit)
        2'd1:    rem_nxt = rem_r + pw_r;
        2'd2:    rem_nxt = rem_r + {pw_r[30:0], 1'b0};
        default: rem_nxt = rem_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r <= '0;
      q3_r  <= '0;
      rem_r <= '0;
      pw_r  <= 32'd1;
    end else begin
      quo_r <= quo_nxt;
      q3_r  <= q3_nxt;
      rem_r <= rem_nxt;
      pw_r  <= pw_nxt;
    end
  end

  assign remainder = rem_r;
endmodule

/* src/rcc_front.sv */
// Front: classifies items and does the load checks.
`timescale 1ns / 1ps
module rcc_front import rcc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output work_t    work
);
  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r [NUM_CLASSES];
  logic [31:0]      last_r [NUM_CLASSES];
  logic             in_range;
  logic [CNT_W-1:0] cnt_sel;
  logic [31:0]      last_sel;
  logic             do_store;

  assign in_range = int'(item.class_exponent) < NUM_CLASSES;

  // Per-class count and last residue lookup
  always_comb begin
    cnt_sel  = '0;
    last_sel = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (item.class_exponent == EXP_W'(c)) begin
        cnt_sel  = cnt_r[c];
        last_sel = last_r[c];
      end
    end
  end

  // Classification; queries always go to the back for the class walk
  always_comb begin
    work          = '0;
    work.value    = item.req_type ? item.query_value : item.entry_residue;
    work.exponent = item.class_exponent;
    do_store      = 1'b0;
    if (item.req_type == REQ_QUERY) begin
      work.is_query = 1'b1;
      work.quick    = 1'b0;
      work.covered  = 1'b0;
      work.status   = ST_OK;
    end else begin
      work.quick = 1'b1;
      if (is_basic(item.class_exponent))                 work.status = ST_BASIC;
      else if (!in_range)                                 work.status = ST_FULL;
      else if (cnt_sel >= CNT_W'(CLASS_DEPTH))            work.status = ST_FULL;
      else if (cnt_sel != '0 && item.entry_residue < last_sel)
                                                          work.status = ST_ORDER;
      else begin
        work.status = ST_OK;
        do_store    = 1'b1;
      end
    end
  end

  // Class bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_r[c]  <= '0;
        last_r[c] <= '0;
      end
    end else if (take && do_store) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (item.class_exponent == EXP_W'(c)) begin
          cnt_r[c]  <= cnt_sel + CNT_W'(1);
          last_r[c] <= item.entry_residue;
        end
      end
    end
  end
endmodule

/* src/rcc_back.sv */
// Back: memory writes and per-class modulo plus binary search.
`timescale 1ns / 1ps
module rcc_back import rcc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wvalid,
  input  work_t     wk,
  output logic      wtake,
  output logic      res_valid,
  output out_item_t res
);
  localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
  localparam int IDX_W  = $clog2(CLASS_DEPTH);
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int ADDR_W = CLS_W + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_PROBE, S_READ, S_CMP, S_DIV, S_ADV, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       mem [2**ADDR_W];
  logic [31:0]       rdata_r;
  logic [CNT_W-1:0]  cnt_r [NUM_CLASSES];
  logic [31:0]       key_r, key_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]  mid;
  logic              cov_r, cov_nxt;
  logic              rv_r, rv_nxt;
  out_item_t         res_r, res_nxt;
  logic              mod_load, mod_div, mod_acc;
  logic [31:0]       mod_rem;
  logic              last_cls;
  logic              basic_hit;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  cnt_w, cnt_c;

  rcc_modunit u_mod (
    .clk(clk), .rst_n(rst_n), .load(mod_load), .dividend(wk.value),
    .div_step(mod_div), .acc_step(mod_acc), .remainder(mod_rem)
  );

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign last_cls = int'(cls_r) == NUM_CLASSES - 1;

  always_comb begin
    cnt_w = '0;
    cnt_c = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (wk.exponent == EXP_W'(c)) cnt_w = cnt_r[c];
      if (cls_r == CLS_W'(c))       cnt_c = cnt_r[c];
    end
  end

  // Fixed congruences, tested as their modulus comes up in the walk
  always_comb begin
    basic_hit = 1'b0;
    if (cls_r == CLS_W'(1) && mod_rem == 32'd2)  basic_hit = 1'b1;
    if (cls_r == CLS_W'(2) && mod_rem == 32'd4)  basic_hit = 1'b1;
    if (cls_r == CLS_W'(4) && mod_rem == 32'd10) basic_hit = 1'b1;
    if (cls_r == CLS_W'(6) && (mod_rem == 32'd604 || mod_rem == 32'd433)) basic_hit = 1'b1;
  end

  // A store is a quick load with status ok
  assign wr_en   = (state_r == S_IDLE) && wvalid && !wk.is_query && (wk.status == ST_OK);
  assign wr_addr = {wk.exponent[CLS_W-1:0], cnt_w[IDX_W-1:0]};
  assign rd_addr = {cls_r, mid[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wk.value;
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt = key_r; cls_nxt = cls_r;
    lo_nxt = lo_r; hi_nxt = hi_r; cov_nxt = cov_r;
    rv_nxt = 1'b0; res_nxt = res_r;
    mod_load = 1'b0; mod_div = 1'b0; mod_acc = 1'b0; wtake = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (wvalid) begin
          wtake = 1'b1;
          if (wk.quick) begin
            rv_nxt  = 1'b1;
            res_nxt = '{covered: wk.covered, status: wk.status};
          end else begin
            mod_load  = 1'b1;
            cls_nxt   = '0;
            cov_nxt   = 1'b0;
            state_nxt = S_NEXT;
          end
        end
      end
      // mod_rem holds n mod 3^cls here
      S_NEXT: begin
        if (basic_hit) begin
          cov_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (cnt_c != '0) begin
          key_nxt   = mod_rem;
          lo_nxt    = '0;
          hi_nxt    = cnt_c;
          state_nxt = S_PROBE;
        end else if (last_cls) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) state_nxt = S_READ;
        else if (last_cls) state_nxt = S_DONE;
        else state_nxt = S_DIV;
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (rdata_r == key_r) begin
          cov_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (rdata_r > key_r) hi_nxt = mid;
          else                 lo_nxt = mid + CNT_W'(1);
          state_nxt = S_PROBE;
        end
      end
      // Step the remainder to the next power of three
      S_DIV: begin
        mod_div   = 1'b1;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        mod_acc   = 1'b1;
        cls_nxt   = cls_r + CLS_W'(1);
        state_nxt = S_NEXT;
      end
      S_DONE: begin
        rv_nxt    = 1'b1;
        res_nxt   = '{covered: cov_r, status: ST_OK};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) cnt_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      if (wr_en) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (wk.exponent == EXP_W'(c)) cnt_r[c] <= cnt_w + CNT_W'(1);
        end
      end
    end
    res_r <= res_nxt;
    key_r <= key_nxt;
    cls_r <= cls_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    cov_r <= cov_nxt;
  end

  assign res_valid = rv_r;
  assign res       = res_r;
endmodule

/* src/rcc_queue.sv */
// Two-entry queue of classified work between front and back.
`timescale 1ns / 1ps
module rcc_queue import rcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output logic  not_empty,
  output logic  full,
  output work_t head
);
  work_t      q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_r[wr_r] <= push_data;
  end

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == 2'd2;
  assign head      = q_r[rd_r];
endmodule

/* src/residue_class_cover_check.sv */
// Residue class cover check: top level with front, queue and back.
// An item is taken at a clock edge with start high and busy low and gives exactly one
// result, strobed for one cycle on out_valid; results cannot be stalled. busy stays high
// from accept until the result strobe, so one transaction is in flight at a time. A load
// passes the queue and the back's result register before its result shows, and the next
// item can be taken once busy falls. A query walks the classes in order,
// stepping n mod 3^e one power at a time with a reciprocal multiply: an empty class
// passes S_NEXT, S_DIV and S_ADV; a loaded class adds S_PROBE before S_DIV and
// S_PROBE, S_READ and S_CMP per binary-search probe of the residue memory (up to
// log2(CLASS_DEPTH)+1 probes); the last class skips S_DIV and S_ADV. The fixed
// congruences are tested as classes 1, 2, 4 and 6 come up, and any hit ends the walk.
// The queue and S_IDLE come before the walk, S_DONE and the result register after it.
`timescale 1ns / 1ps
`include "residue_class_cover_check_defines.svh"
module residue_class_cover_check import rcc_pkg::*; #(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  work_t     fwork, head;
  logic      take, q_ne, q_full, pop;
  logic      rv;
  out_item_t rs;
  logic      busy_r, busy_nxt;

  assign take = start && !busy;

  rcc_front #(.NUM_CLASSES(NUM_CLASSES), .CLASS_DEPTH(CLASS_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_item), .work(fwork)
  );

  rcc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(take), .push_data(fwork), .pop(pop),
    .not_empty(q_ne), .full(q_full), .head(head)
  );

  rcc_back #(.NUM_CLASSES(NUM_CLASSES), .CLASS_DEPTH(CLASS_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .wvalid(q_ne), .wk(head), .wtake(pop),
    .res_valid(rv), .res(rs)
  );

  // One transaction in flight, from accept until its result strobe
  always_comb begin
    busy_nxt = busy_r;
    if (take)    busy_nxt = 1'b1;
    else if (rv) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = rv;
  assign out_item  = rs;

  `RCC_ASSERT_IMP(a_q_no_overflow, clk, rst_n, take, !q_full, "queue overflow")
  `RCC_ASSERT_NXT(a_busy_after_take, clk, rst_n, take, busy, "busy not set after accept")
  `RCC_ASSERT_IMP(a_query_status_ok, clk, rst_n, rv && rs.covered, rs.status == ST_OK,
    "covered with nonzero status")
endmodule

/* verif/residue_class_cover_check_tb.sv */
// Testbench for the residue class cover check: directed table, random loads and queries.
`timescale 1ns / 1ps
module residue_class_cover_check_tb;
  import rcc_pkg::*;

  localparam int NCLS  = NUM_CLASSES_DEF;
  localparam int DEPTH = CLASS_DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 64'd8000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  residue_class_cover_check i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow tables of the residue classes
  logic [31:0] shadow_tab [NCLS][$];
  out_item_t   pending_results [$];
  int          mismatch_count;
  int          checked_count;
  int          load_count;
  int          query_count;
  int          covered_count;
  longint      cycle_count = 0;
  int          send_idle_pct;

  // Directed stimulus table; a known result is typed in where chk is set
  typedef struct {
    in_item_t  item;
    logic      chk;
    out_item_t res;
  } dir_row_t;

  function automatic logic [31:0] power_of_three(input int e);
    logic [31:0] m;
    m = 32'd1;
    for (int i = 0; i < e; i++) m = m * 32'd3;
    return m;
  endfunction

  function automatic logic fixed_congruence(input logic [31:0] n);
    logic [31:0] r729;
    r729 = n % 32'd729;
    return (n % 32'd3 == 32'd2) || (n % 32'd9 == 32'd4) || (n % 32'd81 == 32'd10) ||
           (r729 == 32'd604) || (r729 == 32'd433);
  endfunction

  // Predict the result of one transaction and update the shadow tables
  function automatic out_item_t predict_cover(input in_item_t it);
    out_item_t r;
    int e;
    logic [31:0] key;
    r.covered = 1'b0;
    r.status = ST_OK;
    e = int'(it.class_exponent);
    if (it.req_type == REQ_LOAD) begin
      if (is_basic(it.class_exponent)) begin
        r.status = ST_BASIC;
      end else if (e >= NCLS) begin
        r.status = ST_FULL;
      end else if (shadow_tab[e].size() >= DEPTH) begin
        r.status = ST_FULL;
      end else if (shadow_tab[e].size() > 0 &&
                   it.entry_residue < shadow_tab[e][$]) begin
        r.status = ST_ORDER;
      end else begin
        shadow_tab[e].push_back(it.entry_residue);
      end
    end else if (fixed_congruence(it.query_value)) begin
      r.covered = 1'b1;
    end else begin
      for (int c = 0; c < NCLS; c++) begin
        key = it.query_value % power_of_three(c);
        foreach (shadow_tab[c][i]) if (shadow_tab[c][i] == key) r.covered = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        if (out_item.covered !== pending_results[0].covered)
          report_mismatch($sformatf("covered %b, want %b", out_item.covered,
                                    pending_results[0].covered));
        if (out_item.status !== pending_results[0].status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status,
                                    pending_results[0].status));
        if (out_item.covered === 1'b1) covered_count++;
        void'(pending_results.pop_front());
        checked_count++;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive one transaction, with random idle cycles beforehand
  task automatic send_item(input in_item_t it, input logic has_want, input out_item_t want);
    out_item_t p;
    logic [95:0] noise;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    p = predict_cover(it);
    if (has_want && p !== want)
      report_mismatch($sformatf("table row expects %0d/%0d", want.covered, want.status));
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(p);
    if (it.req_type == REQ_LOAD) load_count++; else query_count++;
    noise = {$urandom, $urandom, $urandom};
    start <= 1'b0;
    in_item <= in_item_t'(noise[$bits(in_item_t)-1:0]);
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t mk_load(input int e, input logic [31:0] r);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.class_exponent = 5'(e);
    it.entry_residue = r;
    it.query_value = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_query(input logic [31:0] n);
    in_item_t it;
    it.req_type = REQ_QUERY;
    it.class_exponent = 5'($urandom);
    it.entry_residue = $urandom;
    it.query_value = n;
    return it;
  endfunction

  function automatic out_item_t res_of(input logic cov, input status_t st);
    out_item_t r;
    r.covered = cov;
    r.status = st;
    return r;
  endfunction

  // Random query: biased toward values that hit a stored residue
  function automatic logic [31:0] pick_query;
    int c;
    logic [31:0] m;
    logic [31:0] k;
    c = $urandom_range(NCLS - 1);
    if ($urandom_range(1) && shadow_tab[c].size() > 0) begin
      m = power_of_three(c);
      k = shadow_tab[c][$urandom_range(shadow_tab[c].size() - 1)];
      return k + m * $urandom_range(32'hFFFF_FFFF / m);
    end
    return $urandom;
  endfunction

  dir_row_t dir_rows [$];
  logic [31:0] cls_next [NCLS];

  initial begin
    dir_row_t row;
    int e;
    logic [31:0] r;
    mismatch_count = 0;
    checked_count = 0;
    load_count = 0;
    query_count = 0;
    covered_count = 0;
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: basic moduli, too large, order, equal, extremes, exponent zero
    row.chk = 1'b1;
    row.item = mk_query(32'd0);            row.res = res_of(1'b0, ST_OK);    dir_rows.push_back(row);
    row.item = mk_query(32'd2);            row.res = res_of(1'b1, ST_OK);    dir_rows.push_back(row);
    row.item = mk_query(32'd604);          row.res = res_of(1'b1, ST_OK);    dir_rows.push_back(row);
    row.item = mk_query(32'd433);          row.res = res_of(1'b1, ST_OK);    dir_rows.push_back(row);
    row.item = mk_query(32'd10);           row.res = res_of(1'b1, ST_OK);    dir_rows.push_back(row);
    row.item = mk_query(32'hFFFF_FFFF);    row.res = res_of(1'b0, ST_OK);    dir_rows.push_back(row);
    row.item = mk_load(1, 32'd5);          row.res = res_of(1'b0, ST_BASIC); dir_rows.push_back(row);
    row.item = mk_load(2, 32'd5);          row.res = res_of(1'b0, ST_BASIC); dir_rows.push_back(row);
    row.item = mk_load(4, 32'd5);          row.res = res_of(1'b0, ST_BASIC); dir_rows.push_back(row);
    row.item = mk_load(6, 32'd5);          row.res = res_of(1'b0, ST_BASIC); dir_rows.push_back(row);
    row.item = mk_load(21, 32'd5);         row.res = res_of(1'b0, ST_FULL);  dir_rows.push_back(row);
    row.item = mk_load(31, 32'hFFFF_FFFF); row.res = res_of(1'b0, ST_FULL);  dir_rows.push_back(row);
    row.item = mk_load(3, 32'd9);          row.res = res_of(1'b0, ST_OK);    dir_rows.push_back(row);
    row.item = mk_load(3, 32'd3);          row.res = res_of(1'b0, ST_ORDER); dir_rows.push_back(row);
    row.item = mk_load(3, 32'd9);          row.res = res_of(1'b0, ST_OK);    dir_rows.push_back(row);
    row.item = mk_load(20, 32'hFFFF_FFFF); row.res = res_of(1'b0, ST_OK);    dir_rows.push_back(row);
    row.chk = 1'b0;
    row.item = mk_query(32'd9);            dir_rows.push_back(row);
    row.item = mk_query(32'd36);           dir_rows.push_back(row);
    row.item = mk_query(32'hFFFF_FFFF);    dir_rows.push_back(row);
    row.item = mk_load(0, 32'd0);          dir_rows.push_back(row);
    row.item = mk_query(32'd0);            dir_rows.push_back(row);
    row.item = mk_query(32'h8000_0000);    dir_rows.push_back(row);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res);
    drain;

    // Fill a small class to depth to reach the class-full case
    for (int i = 0; i < DEPTH + 2; i++) send_item(mk_load(5, 32'(i / 4)), 1'b0, '0);
    drain;
    foreach (cls_next[i]) cls_next[i] = 32'd0;

    // Random phases at idle rates of 0, 69, 0 and 32 percent
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 69 : (ph == 2) ? 0 : 32;
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(99) < 45) begin
          e = $urandom_range(31);
          if ($urandom_range(9) == 0) begin
            r = $urandom; // noise, likely out of order
          end else if (e < NCLS) begin
            r = cls_next[e] + $urandom_range(power_of_three(e) > 32'd64 ?
                                             power_of_three(e) / 64 : 2);
            if (r < cls_next[e]) r = 32'hFFFF_FFFF;
            cls_next[e] = r;
          end else begin
            r = $urandom;
          end
          send_item(mk_load(e, r), 1'b0, '0);
        end else begin
          send_item(mk_query(pick_query()), 1'b0, '0);
        end
      end
      // Hold off until everything outstanding has returned
      drain;
    end

    repeat (40) @(posedge clk);
    $display("covered %0d loads and %0d queries, %0d results checked, %0d covered",
             load_count, query_count, checked_count, covered_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* residue_class_cover_check.f */
+incdir+src
src/rcc_pkg.sv
src/rcc_modunit.sv
src/rcc_front.sv
src/rcc_back.sv
src/rcc_queue.sv
src/residue_class_cover_check.sv
verif/residue_class_cover_check_tb.sv
